### sv/bf3m_pkg.sv
`default_nettype none

package bf3m_pkg;

  // Defaults for the top-level parameters.
  localparam int unsigned DEF_MAX_WIDTH  = 512;
  localparam int unsigned DEF_PIXEL_BITS = 8;

  // Register widths and reset values.
  localparam int unsigned FW_W  = 10;
  localparam int unsigned FH_W  = 13;
  localparam int unsigned CFG_W = 13;
  localparam int unsigned CFG_IDX_W = 1;
  localparam int unsigned FRAME_WIDTH_RST  = 512;
  localparam int unsigned FRAME_HEIGHT_RST = 384;

  // Position counters.
  localparam int unsigned ROW_W      = 12;
  localparam int unsigned CNT_W      = 13;
  localparam int unsigned MIN_SIZE   = 3;
  localparam int unsigned MAX_HEIGHT = 4096;

  // Window geometry.
  localparam int unsigned WIN_COLS = 3;
  localparam int unsigned DIVISOR  = 9;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FRAME_WIDTH  = 1'b0,
    REG_FRAME_HEIGHT = 1'b1
  } bf3m_reg_e;

  // Load enables for the two registered stages of the divider.
  typedef struct packed {
    logic mul_en;
    logic out_en;
  } bf3m_div_ctl_t;

endpackage

`default_nettype wire

### sv/bf3m_ram.sv
`default_nettype none

module bf3m_ram #(
  parameter int unsigned WIDTH  = 16,
  parameter int unsigned DEPTH  = 512,
  parameter int unsigned ADDR_W = $clog2(DEPTH)
) (
  input  wire logic              clk_i,
  input  wire logic              we_i,
  input  wire logic [ADDR_W-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]  wdata_i,
  input  wire logic [ADDR_W-1:0] raddr_i,
  output logic      [WIDTH-1:0]  rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

### sv/bf3m_cell.sv
`default_nettype none

// One window column, held as the sum of its three pixels.
module bf3m_cell #(
  parameter int unsigned WIDTH = 10
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             shift_i,
  input  wire logic [WIDTH-1:0] col_sum_i,
  output logic      [WIDTH-1:0] col_sum_o
);

  logic [WIDTH-1:0] col_sum_q, col_sum_d;

  always_comb begin
    col_sum_d = shift_i ? col_sum_i : col_sum_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_sum_q <= '0;
    end else begin
      col_sum_q <= col_sum_d;
    end
  end

  assign col_sum_o = col_sum_q;

endmodule

`default_nettype wire

### sv/bf3m_div9.sv
`default_nettype none

// Division of the window sum by nine: multiply by a scaled reciprocal, then
// fix the quotient, which can come out at most one too low.
module bf3m_div9 #(
  parameter int unsigned PIXEL_BITS = 8
) (
  input  wire logic                          clk_i,
  input  wire bf3m_pkg::bf3m_div_ctl_t       ctl_i,
  input  wire logic [PIXEL_BITS+4-1:0]       sum_i,
  output logic      [PIXEL_BITS-1:0]         mean_o
);
  import bf3m_pkg::*;

  localparam int unsigned SUM_W    = PIXEL_BITS + 4;
  localparam int unsigned RECIP_SH = SUM_W + 4;
  localparam int unsigned RECIP    = (2 ** RECIP_SH) / DIVISOR;
  localparam int unsigned RECIP_W  = RECIP_SH - 3;
  localparam int unsigned PROD_W   = SUM_W + RECIP_W;
  localparam int unsigned Q_W      = SUM_W - 3;

  logic [PROD_W-1:0]     prod_q, prod_d;
  logic [SUM_W-1:0]      sum_q;
  logic [PIXEL_BITS-1:0] mean_q, mean_d;
  logic [Q_W-1:0]        q_est, q_fix;
  logic [SUM_W-1:0]      nine_est, rem;

  always_comb begin
    prod_d   = PROD_W'(sum_i) * PROD_W'(RECIP_W'(RECIP));
    q_est    = prod_q[PROD_W-1:RECIP_SH];
    nine_est = SUM_W'({q_est, 3'b000}) + SUM_W'(q_est);
    rem      = sum_q - nine_est;
    q_fix    = (rem >= SUM_W'(DIVISOR)) ? q_est + Q_W'(1) : q_est;
    mean_d   = q_fix[PIXEL_BITS-1:0];
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.mul_en) begin
      prod_q <= prod_d;
      sum_q  <= sum_i;
    end
    if (ctl_i.out_en) begin
      mean_q <= mean_d;
    end
  end

  assign mean_o = mean_q;

endmodule

`default_nettype wire

### sv/box_filter_3x3_mean_unit.sv
`default_nettype none

// 3x3 box (mean) filter over one channel of a raster-order pixel stream. One
// pixel is taken per clock cycle while tready is high; the rate is set by the
// line buffer, a single dual-port RAM of MAX_WIDTH entries that holds the two
// previous rows side by side and is read one column ahead of the incoming pixel.
// A pixel at row r >= 2 and column c >= 2 yields one result for the centre
// (r-1, c-1), offered on the output after stages A to D; border pixels yield
// none. The result register and the three stages before it each stall on their
// own, so input stops only when four results wait. tuser on the input marks
// the first pixel of a frame. Frame size comes from two registers, saturated
// to [3, MAX_WIDTH] and [3, 4096]; write them only while the block is idle.
module box_filter_3x3_mean_unit #(
  parameter int unsigned MAX_WIDTH  = bf3m_pkg::DEF_MAX_WIDTH,
  parameter int unsigned PIXEL_BITS = bf3m_pkg::DEF_PIXEL_BITS
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,

  input  wire logic                               cfg_we_i,
  input  wire logic [bf3m_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  wire logic [bf3m_pkg::CFG_W-1:0]         cfg_data_i,

  input  wire logic                               s_axis_tvalid,
  output logic                                    s_axis_tready,
  // pixel
  input  wire logic [((PIXEL_BITS+7)/8)*8-1:0]    s_axis_tdata,
  // frame_start
  input  wire logic                               s_axis_tuser,

  output logic                                    m_axis_tvalid,
  input  wire logic                               m_axis_tready,
  // mean, centre_row, centre_col
  output logic [((PIXEL_BITS+bf3m_pkg::ROW_W+$clog2(MAX_WIDTH)+7)/8)*8-1:0]
                                                  m_axis_tdata
);
  import bf3m_pkg::*;

  localparam int unsigned COL_W   = $clog2(MAX_WIDTH);
  localparam int unsigned CSUM_W  = PIXEL_BITS + 2;
  localparam int unsigned SUM_W   = PIXEL_BITS + 4;
  localparam int unsigned OUT_W   = ((PIXEL_BITS + ROW_W + COL_W + 7) / 8) * 8;

  // Configuration.
  logic [FW_W-1:0] frame_width_q;
  logic [FH_W-1:0] frame_height_q;
  logic [CNT_W-1:0] width_use, height_use, fw_ext, fh_ext;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_width_q  <= FW_W'(FRAME_WIDTH_RST);
      frame_height_q <= FH_W'(FRAME_HEIGHT_RST);
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_FRAME_WIDTH:  frame_width_q  <= cfg_data_i[FW_W-1:0];
        REG_FRAME_HEIGHT: frame_height_q <= cfg_data_i[FH_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    fw_ext = CNT_W'(frame_width_q);
    fh_ext = CNT_W'(frame_height_q);
    if (fw_ext < CNT_W'(MIN_SIZE)) begin
      width_use = CNT_W'(MIN_SIZE);
    end else if (fw_ext > CNT_W'(MAX_WIDTH)) begin
      width_use = CNT_W'(MAX_WIDTH);
    end else begin
      width_use = fw_ext;
    end
    if (fh_ext < CNT_W'(MIN_SIZE)) begin
      height_use = CNT_W'(MIN_SIZE);
    end else if (fh_ext > CNT_W'(MAX_HEIGHT)) begin
      height_use = CNT_W'(MAX_HEIGHT);
    end else begin
      height_use = fh_ext;
    end
  end

  // Handshake chain: each stage takes new data when it is empty or drains.
  logic s_fire;
  logic va_q, vb_q, vc_q, vo_q;
  logic rdy_a, rdy_b, rdy_c, rdy_d;

  assign rdy_d  = ~vo_q | m_axis_tready;
  assign rdy_c  = ~vc_q | rdy_d;
  assign rdy_b  = ~vb_q | rdy_c;
  assign rdy_a  = ~va_q | rdy_b;
  assign s_axis_tready = rdy_a;
  assign s_fire = s_axis_tvalid & rdy_a;

  // Position of the incoming pixel.
  logic [ROW_W-1:0] row_q, row_d, pos_r;
  logic [COL_W-1:0] col_q, col_d, pos_c;
  logic             emit;
  logic [PIXEL_BITS-1:0] pixel;

  assign pixel = s_axis_tdata[PIXEL_BITS-1:0];

  always_comb begin
    pos_r = s_axis_tuser ? '0 : row_q;
    pos_c = s_axis_tuser ? '0 : col_q;
    emit  = (pos_r >= ROW_W'(2)) && (pos_c >= COL_W'(2));
    if (CNT_W'(pos_c) + CNT_W'(1) >= width_use) begin
      col_d = '0;
      if (CNT_W'(pos_r) + CNT_W'(1) >= height_use) begin
        row_d = '0;
      end else begin
        row_d = pos_r + ROW_W'(1);
      end
    end else begin
      col_d = pos_c + COL_W'(1);
      row_d = pos_r;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q <= '0;
      col_q <= '0;
    end else if (s_fire) begin
      row_q <= row_d;
      col_q <= col_d;
    end
  end

  // Line buffer: each entry holds {two rows above, one row above}. It is read
  // at the column of the next pixel, so the data is ready when that pixel
  // arrives. The write and read columns always differ when a pixel is written.
  logic [2*PIXEL_BITS-1:0] lb_rdata, lb_wdata;
  logic [COL_W-1:0]        lb_raddr;
  logic [PIXEL_BITS-1:0]   top_px, mid_px;

  assign top_px   = lb_rdata[2*PIXEL_BITS-1:PIXEL_BITS];
  assign mid_px   = lb_rdata[PIXEL_BITS-1:0];
  assign lb_wdata = {mid_px, pixel};
  assign lb_raddr = s_fire ? col_d : col_q;

  bf3m_ram #(
    .WIDTH (2 * PIXEL_BITS),
    .DEPTH (MAX_WIDTH),
    .ADDR_W(COL_W)
  ) u_line_buf (
    .clk_i  (clk_i),
    .we_i   (s_fire),
    .waddr_i(pos_c),
    .wdata_i(lb_wdata),
    .raddr_i(lb_raddr),
    .rdata_o(lb_rdata)
  );

  // Window: a chain of column cells, the newest column entering at cell 0.
  logic [CSUM_W-1:0] new_col_sum;
  logic [CSUM_W-1:0] cell_sum [WIN_COLS];

  assign new_col_sum = CSUM_W'(top_px) + CSUM_W'(mid_px) + CSUM_W'(pixel);

  for (genvar gi = 0; gi < WIN_COLS; gi++) begin : g_cell
    bf3m_cell #(
      .WIDTH(CSUM_W)
    ) u_cell (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .shift_i  (s_fire),
      .col_sum_i((gi == 0) ? new_col_sum : cell_sum[(gi == 0) ? 0 : gi - 1]),
      .col_sum_o(cell_sum[gi])
    );
  end

  logic [SUM_W-1:0] win_sum;
  assign win_sum = SUM_W'(cell_sum[0]) + SUM_W'(cell_sum[1]) + SUM_W'(cell_sum[2]);

  // Stage A: window is complete, centre position noted.
  // Stage B: window sum. Stage C: reciprocal product. Stage D: result.
  logic [ROW_W-1:0] row_a_q, row_b_q, row_c_q, row_o_q;
  logic [COL_W-1:0] col_a_q, col_b_q, col_c_q, col_o_q;
  logic [SUM_W-1:0] sum_b_q;
  logic [PIXEL_BITS-1:0] mean;
  bf3m_div_ctl_t    div_ctl;

  assign div_ctl.mul_en = rdy_c & vb_q;
  assign div_ctl.out_en = rdy_d & vc_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
      vb_q <= 1'b0;
      vc_q <= 1'b0;
      vo_q <= 1'b0;
    end else begin
      if (rdy_a) va_q <= s_fire & emit;
      if (rdy_b) vb_q <= va_q;
      if (rdy_c) vc_q <= vb_q;
      if (rdy_d) vo_q <= vc_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_fire) begin
      row_a_q <= pos_r - ROW_W'(1);
      col_a_q <= pos_c - COL_W'(1);
    end
    if (rdy_b && va_q) begin
      sum_b_q <= win_sum;
      row_b_q <= row_a_q;
      col_b_q <= col_a_q;
    end
    if (div_ctl.mul_en) begin
      row_c_q <= row_b_q;
      col_c_q <= col_b_q;
    end
    if (div_ctl.out_en) begin
      row_o_q <= row_c_q;
      col_o_q <= col_c_q;
    end
  end

  bf3m_div9 #(
    .PIXEL_BITS(PIXEL_BITS)
  ) u_div9 (
    .clk_i (clk_i),
    .ctl_i (div_ctl),
    .sum_i (sum_b_q),
    .mean_o(mean)
  );

  assign m_axis_tvalid = vo_q;
  assign m_axis_tdata  = OUT_W'({col_o_q, row_o_q, mean});

  // A pixel that completes an interior window enters stage A.
  a_emit_enters: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_fire && emit |=> va_q)
    else $error("completed window did not enter stage A");

  // With every stage full and the output stalled, no pixel may be taken.
  a_full_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    va_q && vb_q && vc_q && vo_q && !m_axis_tready |-> !s_axis_tready)
    else $error("pixel taken while pipeline is full");

  // The first pixel of a frame leaves the position at row 0, column 1.
  a_frame_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_fire && s_axis_tuser |=> (row_q == '0) && (col_q == COL_W'(1)))
    else $error("frame start did not reset the position");

  // A result never names a centre in row 0 or column 0.
  a_centre_interior: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vo_q |-> (row_o_q != '0) && (col_o_q != '0))
    else $error("result for a border pixel");

endmodule

`default_nettype wire

### tb/testbench.sv
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import bf3m_pkg::*;

  localparam int unsigned IN_W          = ((DEF_PIXEL_BITS + 7) / 8) * 8;
  localparam int unsigned COL_W         = $clog2(DEF_MAX_WIDTH);
  localparam int unsigned OUT_W         = ((DEF_PIXEL_BITS + ROW_W + COL_W + 7) / 8) * 8;
  localparam int unsigned WIN_CELLS     = WIN_COLS * WIN_COLS;
  localparam int unsigned SETTLE_CYCLES = 8;
  localparam int unsigned CYCLE_LIMIT   = 1_000_000;

  typedef struct {
    bit [DEF_PIXEL_BITS-1:0] mean;
    bit [ROW_W-1:0]          row;
    bit [COL_W-1:0]          col;
  } window_mean_t;

  class box_mean_tracker;
    bit [FW_W-1:0]           width_reg  = FW_W'(FRAME_WIDTH_RST);
    bit [FH_W-1:0]           height_reg = FH_W'(FRAME_HEIGHT_RST);
    bit [DEF_PIXEL_BITS-1:0] line_above     [DEF_MAX_WIDTH];
    bit [DEF_PIXEL_BITS-1:0] line_two_above [DEF_MAX_WIDTH];
    bit [DEF_PIXEL_BITS-1:0] win [WIN_CELLS];
    bit [ROW_W-1:0]          row;
    bit [COL_W-1:0]          col;
    window_mean_t            pending_means [$];
    int unsigned             errors;

    function void write_register(bf3m_reg_e idx, bit [CFG_W-1:0] value);
      case (idx)
        REG_FRAME_WIDTH:  width_reg  = value[FW_W-1:0];
        REG_FRAME_HEIGHT: height_reg = value[FH_W-1:0];
        default: ;
      endcase
    endfunction

    function void note_pixel(bit [DEF_PIXEL_BITS-1:0] px, bit frame_start);
      int unsigned w, h, r, c, sum, i;
      bit [DEF_PIXEL_BITS-1:0] top, mid;
      window_mean_t m;
      w = (width_reg < MIN_SIZE) ? MIN_SIZE :
          (width_reg > DEF_MAX_WIDTH) ? DEF_MAX_WIDTH : width_reg;
      h = (height_reg < MIN_SIZE) ? MIN_SIZE :
          (height_reg > MAX_HEIGHT) ? MAX_HEIGHT : height_reg;
      if (frame_start) begin
        row = '0;
        col = '0;
      end
      r = row;
      c = col;
      top = line_two_above[c];
      mid = line_above[c];
      line_two_above[c] = mid;
      line_above[c] = px;
      // The rightmost window column takes the newest pixel of each of the three rows.
      for (i = 0; i < WIN_COLS; i++) begin
        win[i*WIN_COLS]     = win[i*WIN_COLS + 1];
        win[i*WIN_COLS + 1] = win[i*WIN_COLS + 2];
      end
      win[2] = top;
      win[5] = mid;
      win[8] = px;
      if (r >= 2 && c >= 2) begin
        sum = 0;
        for (i = 0; i < WIN_CELLS; i++) sum += win[i];
        m.mean = DEF_PIXEL_BITS'(sum / DIVISOR);
        m.row  = ROW_W'(r - 1);
        m.col  = COL_W'(c - 1);
        pending_means.push_back(m);
      end
      if (c + 1 >= w) begin
        col = '0;
        row = (r + 1 >= h) ? '0 : ROW_W'(r + 1);
      end else begin
        col = COL_W'(c + 1);
      end
    endfunction

    function void check_result(logic [OUT_W-1:0] data);
      window_mean_t m;
      if (pending_means.size() == 0) begin
        $error("result transfer with nothing pending: tdata %h", data);
        errors++;
        return;
      end
      m = pending_means.pop_front();
      if (data[DEF_PIXEL_BITS-1:0] !== m.mean) begin
        $error("mean: expected %0d, actual %0d", m.mean, data[DEF_PIXEL_BITS-1:0]);
        errors++;
      end
      if (data[DEF_PIXEL_BITS +: ROW_W] !== m.row) begin
        $error("centre_row: expected %0d, actual %0d", m.row,
               data[DEF_PIXEL_BITS +: ROW_W]);
        errors++;
      end
      if (data[DEF_PIXEL_BITS+ROW_W +: COL_W] !== m.col) begin
        $error("centre_col: expected %0d, actual %0d", m.col,
               data[DEF_PIXEL_BITS+ROW_W +: COL_W]);
        errors++;
      end
    endfunction
  endclass

  logic                 clk_i         = 1'b0;
  logic                 rst_ni        = 1'b0;
  logic                 cfg_we_i      = 1'b0;
  bf3m_reg_e            cfg_idx_i     = REG_FRAME_WIDTH;
  logic [CFG_W-1:0]     cfg_data_i    = '0;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [IN_W-1:0]      s_axis_tdata  = '0;   // pixel
  logic                 s_axis_tuser  = 1'b0; // frame_start
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic [OUT_W-1:0]     m_axis_tdata;         // mean, centre_row, centre_col

  box_mean_tracker tracker;
  int unsigned     rx_stall_pct;
  int unsigned     hold_request;

  box_filter_3x3_mean_unit dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  initial begin
    int unsigned cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycles++;
    end
    $display("testbench failed");
    $finish;
  end

  // Result side: checks each transfer and picks the next tready. A hold-off
  // request loads a countdown that keeps tready low until it runs out.
  initial begin
    int unsigned hold_left;
    hold_left = 0;
    forever begin
      @(posedge clk_i);
      if (m_axis_tvalid && m_axis_tready) tracker.check_result(m_axis_tdata);
      if (hold_request != 0) begin
        hold_left = hold_request;
        hold_request = 0;
      end
      if (hold_left != 0) begin
        m_axis_tready <= 1'b0;
        hold_left--;
      end else begin
        m_axis_tready <= ($urandom_range(0, 99) >= rx_stall_pct);
      end
    end
  end

  task automatic send_pixel(bit [IN_W-1:0] px, bit frame_start);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= px;
    s_axis_tuser  <= frame_start;
    do @(posedge clk_i); while (!s_axis_tready);
    tracker.note_pixel(px, frame_start);
  endtask

  task automatic wait_results();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (tracker.pending_means.size() != 0);
  endtask

  task automatic set_frame_size(bit [CFG_W-1:0] w, bit [CFG_W-1:0] h);
    wait_results();
    // Border pixels yield no result and leave stage A empty.
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= REG_FRAME_WIDTH;
    cfg_data_i <= w;
    @(posedge clk_i);
    tracker.write_register(REG_FRAME_WIDTH, w);
    cfg_idx_i  <= REG_FRAME_HEIGHT;
    cfg_data_i <= h;
    @(posedge clk_i);
    tracker.write_register(REG_FRAME_HEIGHT, h);
    cfg_we_i   <= 1'b0;
  endtask

  // A new size always opens with a frame start, so no result uses a line buffer
  // column that the current frame has not written.
  task automatic stream_pixels(int unsigned count, int unsigned idle_pct,
                               int unsigned frame_gap, bit open_frame);
    int unsigned i;
    bit [IN_W-1:0] px;
    bit fs;
    for (i = 0; i < count; i++) begin
      case ($urandom_range(0, 7))
        0:       px = '0;
        1:       px = '1;
        default: px = IN_W'($urandom);
      endcase
      fs = (i == 0 && open_frame) ||
           (frame_gap != 0 && $urandom_range(1, frame_gap) == 1);
      while ($urandom_range(0, 99) < idle_pct) begin
        s_axis_tvalid <= 1'b0;
        @(posedge clk_i);
      end
      send_pixel(px, fs);
    end
  endtask

  initial begin
    int unsigned i;
    tracker = new();
    rx_stall_pct = 0;
    hold_request = 0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Smallest frame: all white, then all black after a wrap without frame
    // start, then a frame start in the middle of a frame.
    set_frame_size(CFG_W'(3), CFG_W'(3));
    for (i = 0; i < 25; i++) begin
      send_pixel((i < 9) ? 8'hFF : (i < 18) ? 8'h00 : 8'h01 << (i - 18),
                 (i == 0 || i == 21));
    end

    // Narrowest rows with the height register at its top value.
    set_frame_size(CFG_W'(0), CFG_W'(13'h1FFF));
    stream_pixels(120, 0, 0, 1'b1);

    // Widest rows, height saturated up from zero; the third row starts at
    // pixel 1024.
    rx_stall_pct = 22;
    set_frame_size(CFG_W'(13'h3FF), CFG_W'(0));
    stream_pixels(1050, 22, 0, 1'b1);

    // Width written with bits above the register.
    rx_stall_pct = 0;
    set_frame_size(CFG_W'(13'h1C05), CFG_W'(4));
    stream_pixels(80, 86, 40, 1'b1);

    // Receiver stalls; the sender pauses halfway until everything is out.
    rx_stall_pct = 86;
    set_frame_size(CFG_W'(7), CFG_W'(6));
    stream_pixels(60, 0, 40, 1'b1);
    wait_results();
    stream_pixels(60, 0, 40, 1'b0);

    rx_stall_pct = 22;
    set_frame_size(CFG_W'(2), CFG_W'(2));
    stream_pixels(50, 22, 30, 1'b1);

    // Long receiver hold-off while the sender keeps offering pixels.
    rx_stall_pct = 0;
    set_frame_size(CFG_W'(17), CFG_W'(9));
    hold_request = 300;
    stream_pixels(100, 0, 0, 1'b1);

    wait_results();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (tracker.errors == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

endmodule
